@@ rtl/ihpl_pkg.sv @@
// Shared types, register codes and reset values for the IMU heater PID loop.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ihpl_pkg;

    // Default number of fraction bits in the gains and the PID terms
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Configuration port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_DIVIDER = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET    = 4'd7;

    // Reset values
    localparam logic signed [12:0] SETPOINT_RST       = 13'sd320;
    localparam logic [23:0]        GAIN_P_RST         = 24'd13107200;
    localparam logic [23:0]        GAIN_I_RST         = 24'd1638;
    localparam logic [23:0]        GAIN_D_RST         = 24'd0;
    localparam logic [15:0]        OUTPUT_LIMIT_RST   = 16'd4499;
    localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd4399;
    localparam logic [7:0]         UPDATE_DIVIDER_RST = 8'd1;
    localparam logic signed [10:0] TEMP_OFFSET_RST    = 11'sd184;

    // Datapath widths
    localparam int TEMP_W = 12;   // measured temperature
    localparam int ERR_W  = 15;   // error and error difference
    localparam int PROD_W = 40;   // 25-bit signed gain times 15-bit signed error

    typedef struct packed {
        logic signed [12:0] setpoint;
        logic [23:0]        gain_p;
        logic [23:0]        gain_i;
        logic [23:0]        gain_d;
        logic [15:0]        output_limit;
        logic [15:0]        integral_limit;
        logic [7:0]         update_divider;
        logic signed [10:0] temp_offset;
    } ihpl_cfg_t;

    // Products handed from the front stage to the back stage
    typedef struct packed {
        logic signed [PROD_W-1:0] pterm;
        logic signed [PROD_W-1:0] iprod;
        logic signed [PROD_W-1:0] dterm;
        logic signed [TEMP_W-1:0] temperature;
    } ihpl_mid_t;

endpackage

`default_nettype wire

@@ rtl/ihpl_cfg_regs.sv @@
// Configuration register file for the IMU heater PID loop.
// Depends on ihpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihpl_cfg_regs
    import ihpl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output ihpl_cfg_t                  cfg
);

    ihpl_cfg_t cfg_reg;
    ihpl_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SETPOINT:       cfg_next.setpoint       = signed'(wr_data[12:0]);
                REG_GAIN_P:         cfg_next.gain_p         = wr_data;
                REG_GAIN_I:         cfg_next.gain_i         = wr_data;
                REG_GAIN_D:         cfg_next.gain_d         = wr_data;
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = wr_data[15:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = wr_data[15:0];
                REG_UPDATE_DIVIDER: cfg_next.update_divider = wr_data[7:0];
                REG_TEMP_OFFSET:    cfg_next.temp_offset    = signed'(wr_data[10:0]);
                default:            cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint       <= SETPOINT_RST;
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RST;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RST;
            cfg_reg.update_divider <= UPDATE_DIVIDER_RST;
            cfg_reg.temp_offset    <= TEMP_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ihpl_front.sv @@
// Front stage: input register, temperature, sample divider, error and the
// three gain products, registered for the back stage. Depends on ihpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihpl_front
    import ihpl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ihpl_cfg_t  cfg,
    // sample channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] temp_high_byte,
    input  wire logic [7:0] temp_low_byte,
    // towards back stage
    output logic            mid_valid,
    input  wire logic       mid_ready,
    output ihpl_mid_t       mid
);

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] hi_reg;
    logic [7:0] lo_reg;

    logic [7:0]              wait_cnt_reg;
    logic [7:0]              wait_cnt_next;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;

    logic      mid_vld_reg;
    logic      mid_vld_next;
    ihpl_mid_t mid_reg;

    logic signed [10:0]       raw_count;
    logic signed [TEMP_W-1:0] temp_val;
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  err_diff;
    logic signed [24:0]       gp;
    logic signed [24:0]       gi;
    logic signed [24:0]       gd;
    logic signed [PROD_W-1:0] pterm;
    logic signed [PROD_W-1:0] iprod;
    logic signed [PROD_W-1:0] dterm;
    logic                     skip;
    logic                     mid_free;
    logic                     s1_go;

    assign raw_count = signed'({hi_reg, lo_reg[7:5]});
    assign temp_val  = TEMP_W'(raw_count) + TEMP_W'(cfg.temp_offset);
    assign err       = ERR_W'(cfg.setpoint) - ERR_W'(temp_val);
    assign err_diff  = err - prev_err_reg;

    assign gp = signed'({1'b0, cfg.gain_p});
    assign gi = signed'({1'b0, cfg.gain_i});
    assign gd = signed'({1'b0, cfg.gain_d});

    assign pterm = gp * err;
    assign iprod = gi * err;
    assign dterm = gd * err_diff;

    // Waiting samples give no result and only advance the counter
    assign skip = (cfg.update_divider > 8'd1) &&
                  (wait_cnt_reg < (cfg.update_divider - 8'd1));

    assign mid_free = !mid_vld_reg || mid_ready;
    assign s1_go    = in_vld_reg && (skip || mid_free);
    assign in_ready = !in_vld_reg || s1_go;

    always_comb
    begin
        in_vld_next   = in_vld_reg;
        wait_cnt_next = wait_cnt_reg;
        prev_err_next = prev_err_reg;
        mid_vld_next  = mid_vld_reg;

        if (mid_ready)
            mid_vld_next = 1'b0;

        if (s1_go)
        begin
            in_vld_next = 1'b0;
            if (skip)
            begin
                wait_cnt_next = wait_cnt_reg + 8'd1;
            end
            else
            begin
                wait_cnt_next = 8'd0;
                prev_err_next = err;
                mid_vld_next  = 1'b1;
            end
        end

        if (in_valid && in_ready)
            in_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            wait_cnt_reg <= '0;
            prev_err_reg <= '0;
            mid_vld_reg  <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            wait_cnt_reg <= wait_cnt_next;
            prev_err_reg <= prev_err_next;
            mid_vld_reg  <= mid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hi_reg <= temp_high_byte;
            lo_reg <= temp_low_byte;
        end
        if (s1_go && !skip)
        begin
            mid_reg.pterm       <= pterm;
            mid_reg.iprod       <= iprod;
            mid_reg.dterm       <= dterm;
            mid_reg.temperature <= temp_val;
        end
    end

    assign mid_valid = mid_vld_reg;
    assign mid       = mid_reg;

endmodule

`default_nettype wire

@@ rtl/ihpl_back.sv @@
// Back stage: integral accumulate and clamp, output sum and clamp, duty,
// and the result register. Depends on ihpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihpl_back
    import ihpl_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ihpl_cfg_t           cfg,
    input  wire logic                mid_valid,
    output logic                     mid_ready,
    input  wire ihpl_mid_t           mid,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [15:0]              heater_duty,
    output logic signed [TEMP_W-1:0] temperature
);

    // Integral holds at most the limit scaled by the fraction bits
    localparam int LIM_W = 16 + GAIN_FRAC_BITS + 1;
    localparam int MAG_W = (16 + GAIN_FRAC_BITS > PROD_W - 2) ?
                           16 + GAIN_FRAC_BITS : PROD_W - 2;
    localparam int SUM_W = MAG_W + 3;

    logic signed [LIM_W-1:0] integ_reg;
    logic signed [LIM_W-1:0] integ_next;

    logic                     out_vld_reg;
    logic                     out_vld_next;
    logic [15:0]              duty_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic signed [SUM_W-1:0] ilim;
    logic signed [SUM_W-1:0] olim;
    logic signed [SUM_W-1:0] isum;
    logic signed [SUM_W-1:0] iclamp;
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] tclamp;
    logic [15:0]             duty;
    logic                    take;

    assign ilim = signed'(SUM_W'({cfg.integral_limit, {GAIN_FRAC_BITS{1'b0}}}));
    assign olim = signed'(SUM_W'({cfg.output_limit, {GAIN_FRAC_BITS{1'b0}}}));

    assign isum = SUM_W'(integ_reg) + SUM_W'(mid.iprod);

    always_comb
    begin
        if (isum > ilim)
            iclamp = ilim;
        else if (isum < -ilim)
            iclamp = -ilim;
        else
            iclamp = isum;
    end

    assign integ_next = LIM_W'(iclamp);
    assign total      = SUM_W'(mid.pterm) + iclamp + SUM_W'(mid.dterm);

    // Clamp to the output limit, then drop negatives
    always_comb
    begin
        if (total > olim)
            tclamp = olim;
        else if (total < 0)
            tclamp = '0;
        else
            tclamp = total;
    end

    assign duty = tclamp[GAIN_FRAC_BITS +: 16];

    assign mid_ready = !out_vld_reg || out_ready;
    assign take      = mid_valid && mid_ready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_ready)
            out_vld_next = 1'b0;
        if (take)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (take)
                integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            duty_reg <= duty;
            temp_reg <= mid.temperature;
        end
    end

    assign out_valid   = out_vld_reg;
    assign heater_duty = duty_reg;
    assign temperature = temp_reg;

endmodule

`default_nettype wire

@@ rtl/imu_heater_pid_loop_core.sv @@
// Top level of the IMU heater PID loop: config registers, front and back stages.
// Depends on ihpl_pkg, ihpl_cfg_regs, ihpl_front and ihpl_back.
//
// One temperature sample is taken per transfer on the input channel as two
// raw sensor bytes; the upper byte and the top three bits of the lower byte
// form an 11-bit signed count, to which temp_offset is added to give the
// temperature in eighths of a degree. A wait counter runs the controller once
// every update_divider samples (0 or 1: every sample); a sample that only
// advances the counter produces no result transfer. When the controller runs,
// a positional PID step is taken against setpoint: the integral is clamped to
// +-integral_limit, the total to output_limit, negatives go to zero and the
// integer part is returned as heater_duty together with the temperature.
// Gains carry GAIN_FRAC_BITS fraction bits. The datapath is three registers
// deep (input, products, result); one sample is accepted every cycle as
// long as results are taken, set by the single pass through the product
// and accumulate stages. A result that is not taken holds the result
// register; samples behind it keep moving until each stage is full, and
// only then does the input stall. Configuration writes are always accepted
// and must be issued while the block is idle; writes to an index above
// seven are dropped.
`timescale 1ns / 1ps
`default_nettype none

module imu_heater_pid_loop_core
    import ihpl_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            temp_high_byte,
    input  wire logic [7:0]            temp_low_byte,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [15:0]                heater_duty,
    output logic signed [TEMP_W-1:0]   temperature
);

    ihpl_cfg_t cfg;
    ihpl_mid_t mid;
    logic      mid_valid;
    logic      mid_ready;

    // Register file takes a write whenever one is offered, so it never stalls a transfer
    assign cfg_ready = 1'b1;

    ihpl_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Temperature, divider, error and products
    ihpl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .temp_high_byte (temp_high_byte),
        .temp_low_byte  (temp_low_byte),
        .mid_valid      (mid_valid),
        .mid_ready      (mid_ready),
        .mid            (mid)
    );

    // Integral, clamps and result register
    ihpl_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .mid_valid   (mid_valid),
        .mid_ready   (mid_ready),
        .mid         (mid),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .heater_duty (heater_duty),
        .temperature (temperature)
    );

endmodule

`default_nettype wire

@@ rtl/ihpl_checker.sv @@
// Port-level checks for the IMU heater PID loop, bound to the top level.
// Depends on ihpl_pkg and imu_heater_pid_loop_core.
`timescale 1ns / 1ps
`default_nettype none

module ihpl_checker
    import ihpl_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [15:0]           heater_duty,
    input wire logic signed [TEMP_W-1:0] temperature
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heater_duty) && $stable(temperature))
        else $error("result changed while stalled");

    // With the result register empty nothing downstream can block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Register writes never wait
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

    // Temperature is at most 2046 eighths of a degree
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature != 12'sd2047)
        else $error("temperature out of range");

endmodule

bind imu_heater_pid_loop_core ihpl_checker u_ihpl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .heater_duty (heater_duty),
    .temperature (temperature)
);

`default_nettype wire
